>>> rtl/mer_pkg.sv
// shared types, control word layout and microcode table of the ellipse rasterizer
package mer_pkg;

  localparam int STEP_BITS = 34;
  localparam int DEC_BITS  = 48;
  localparam int PC_BITS   = 5;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [2:0] {
    MA_RX, MA_RY, MA_RX2, MA_RY2, MA_X, MA_YM1
  } ma_t;

  typedef enum logic [2:0] {
    MB_RX, MB_RY, MB_X, MB_YM1, MB_T_LO, MB_T_HI, MB_RY2_LO, MB_RY2_HI
  } mb_t;

  typedef enum logic [2:0] {
    AC_NONE, AC_LOAD_Q, AC_ADD, AC_ADD_SH, AC_SUB, AC_SUB_SH
  } acc_op_t;

  typedef enum logic [1:0] {
    T_NONE, T_PROD_X, T_PROD
  } t_op_t;

  typedef enum logic [3:0] {
    WR_NONE, WR_RX2, WR_RY2, WR_INIT, WR_R2START, WR_ADV_R1, WR_ADV_R2,
    WR_DEC_ADD_DX, WR_DEC_ADD_RY2, WR_DEC_SUB_DY, WR_DEC_ADD_RX2, WR_CHK_DONE
  } wr_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_PIX0, EM_PIX1, EM_PIX2, EM_PIX3, EM_NULL
  } emit_t;

  typedef enum logic [2:0] {
    JC_NONE, JC_ALWAYS, JC_IN2, JC_SKIP, JC_NO_R1END
  } jc_t;

  typedef struct packed {
    ma_t                 ma;
    mb_t                 mb;
    acc_op_t             acc;
    t_op_t               top;
    wr_t                 wr;
    emit_t               emit;
    jc_t                 jc;
    logic [PC_BITS-1:0]  target;
    logic                item_end;
  } ctrl_t;

  typedef struct packed {
    logic in2;
    logic done;
    logic skip;
    logic r1_live;
    logic out_free;
  } stat_t;

  // program addresses
  localparam logic [PC_BITS-1:0] PC_ST0  = 5'd0;
  localparam logic [PC_BITS-1:0] PC_ST1  = 5'd1;
  localparam logic [PC_BITS-1:0] PC_ST2  = 5'd2;
  localparam logic [PC_BITS-1:0] PC_ST3  = 5'd3;
  localparam logic [PC_BITS-1:0] PC_PX0  = 5'd4;
  localparam logic [PC_BITS-1:0] PC_PX1  = 5'd5;
  localparam logic [PC_BITS-1:0] PC_PX2  = 5'd6;
  localparam logic [PC_BITS-1:0] PC_PX3  = 5'd7;
  localparam logic [PC_BITS-1:0] PC_A1   = 5'd8;
  localparam logic [PC_BITS-1:0] PC_A2   = 5'd9;
  localparam logic [PC_BITS-1:0] PC_A3   = 5'd10;
  localparam logic [PC_BITS-1:0] PC_A4   = 5'd11;
  localparam logic [PC_BITS-1:0] PC_B1   = 5'd12;
  localparam logic [PC_BITS-1:0] PC_B2   = 5'd13;
  localparam logic [PC_BITS-1:0] PC_B3   = 5'd14;
  localparam logic [PC_BITS-1:0] PC_B4   = 5'd15;
  localparam logic [PC_BITS-1:0] PC_SET0 = 5'd16;
  localparam logic [PC_BITS-1:0] PC_R1   = 5'd17;
  localparam logic [PC_BITS-1:0] PC_R2   = 5'd18;
  localparam logic [PC_BITS-1:0] PC_R3   = 5'd19;
  localparam logic [PC_BITS-1:0] PC_R4   = 5'd20;
  localparam logic [PC_BITS-1:0] PC_R5   = 5'd21;
  localparam logic [PC_BITS-1:0] PC_R6   = 5'd22;
  localparam logic [PC_BITS-1:0] PC_R7   = 5'd23;
  localparam logic [PC_BITS-1:0] PC_R8   = 5'd24;
  localparam logic [PC_BITS-1:0] PC_R9   = 5'd25;
  localparam logic [PC_BITS-1:0] PC_R10  = 5'd26;
  localparam logic [PC_BITS-1:0] PC_CHK  = 5'd27;
  localparam logic [PC_BITS-1:0] PC_NUL  = 5'd28;
  localparam logic [PC_BITS-1:0] PC_LAST = PC_NUL;

  localparam ctrl_t CTRL_NOP = '{ma: MA_RX, mb: MB_RX, acc: AC_NONE, top: T_NONE,
                                 wr: WR_NONE, emit: EM_NONE, jc: JC_NONE,
                                 target: '0, item_end: 1'b0};

  function automatic ctrl_t mer_rom(input logic [PC_BITS-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    case (pc)
      // start: square radii, set up decision and slope terms
      PC_ST0: begin
        w.ma = MA_RX; w.mb = MB_RX;
      end
      PC_ST1: begin
        w.wr = WR_RX2; w.ma = MA_RY; w.mb = MB_RY;
      end
      PC_ST2: begin
        w.wr = WR_RY2; w.ma = MA_RX2; w.mb = MB_RY;
      end
      PC_ST3: begin
        w.wr = WR_INIT; w.jc = JC_ALWAYS; w.target = PC_SET0;
      end
      // step: four symmetric pixels
      PC_PX0: w.emit = EM_PIX0;
      PC_PX1: w.emit = EM_PIX1;
      PC_PX2: w.emit = EM_PIX2;
      PC_PX3: begin
        w.emit = EM_PIX3; w.jc = JC_IN2; w.target = PC_B1;
      end
      // region one advance
      PC_A1: w.wr = WR_ADV_R1;
      PC_A2: w.wr = WR_DEC_ADD_DX;
      PC_A3: begin
        w.wr = WR_DEC_ADD_RY2; w.jc = JC_SKIP; w.target = PC_SET0;
      end
      PC_A4: begin
        w.wr = WR_DEC_SUB_DY; w.jc = JC_ALWAYS; w.target = PC_SET0;
      end
      // region two advance
      PC_B1: w.wr = WR_ADV_R2;
      PC_B2: w.wr = WR_DEC_ADD_RX2;
      PC_B3: begin
        w.wr = WR_DEC_SUB_DY; w.jc = JC_SKIP; w.target = PC_SET0;
      end
      PC_B4: w.wr = WR_DEC_ADD_DX;
      // region change check and region two start value
      PC_SET0: begin
        w.jc = JC_NO_R1END; w.target = PC_CHK; w.ma = MA_X; w.mb = MB_X;
      end
      PC_R1: begin
        w.top = T_PROD_X; w.acc = AC_LOAD_Q; w.ma = MA_RX2; w.mb = MB_RY2_LO;
      end
      PC_R2: begin
        w.acc = AC_SUB; w.ma = MA_RX2; w.mb = MB_RY2_HI;
      end
      PC_R3: begin
        w.acc = AC_SUB_SH; w.ma = MA_RY2; w.mb = MB_T_LO;
      end
      PC_R4: begin
        w.acc = AC_ADD; w.ma = MA_RY2; w.mb = MB_T_HI;
      end
      PC_R5: begin
        w.acc = AC_ADD_SH; w.ma = MA_YM1; w.mb = MB_YM1;
      end
      PC_R6: w.top = T_PROD;
      PC_R7: begin
        w.ma = MA_RX2; w.mb = MB_T_LO;
      end
      PC_R8: begin
        w.acc = AC_ADD; w.ma = MA_RX2; w.mb = MB_T_HI;
      end
      PC_R9:  w.acc = AC_ADD_SH;
      PC_R10: w.wr = WR_R2START;
      PC_CHK: begin
        w.wr = WR_CHK_DONE; w.item_end = 1'b1;
      end
      PC_NUL: begin
        w.emit = EM_NULL; w.item_end = 1'b1;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/mer_if.sv
// valid/ready channel interfaces for the ellipse rasterizer requests and pixels
interface mer_in_if #(parameter int COORD_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] radius_x;
  logic [COORD_BITS-1:0] radius_y;

  modport source (output valid, operation, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink (input valid, operation, center_x, center_y, radius_x, radius_y,
                output ready);
endinterface

interface mer_out_if #(parameter int COORD_BITS = 10);
  localparam int PW = COORD_BITS + 2;
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] pixel_x;
  logic signed [PW-1:0] pixel_y;
  logic                 pixel_valid;
  logic                 last_of_step;
  logic                 finished;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, last_of_step, finished,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_valid, last_of_step, finished,
                output ready);
endinterface

>>> rtl/midpoint_ellipse_rasterizer.sv
// top level: microcoded sequencer driving the midpoint ellipse datapath
// start request: squares the radii, sets up the decision and slope terms, and computes
//   the region two start value when region two begins at once
// step request: four pixels, then the decision update; the region two start value follows
//   when the arc moves into region two, and a stalled output holds an emitting step
// step after the arc is done: one result, the empty one, marked last and finished
// synchronous active-low reset: sequencer idle, output empty, nothing to draw
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);
  import mer_pkg::*;

  // sequencer state: busy flag and step counter
  logic               busy_r, busy_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;

  ctrl_t ctrl;
  stat_t stat;
  logic  accept;
  logic  load;
  logic  go;
  logic  take;

  // one request at a time; the output register lets the next one in
  // while the last pixel still waits downstream
  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign load        = accept && (in_ch.operation == OP_START);

  // idle cycles issue a no-op control word
  assign ctrl = busy_r ? mer_rom(pc_r) : CTRL_NOP;

  // an emitting step holds until the output register is free
  assign go = (ctrl.emit == EM_NONE) || stat.out_free;

  // conditional jumps of the microprogram
  always_comb begin
    case (ctrl.jc)
      JC_ALWAYS:   take = 1'b1;
      JC_IN2:      take = stat.in2;
      JC_SKIP:     take = stat.skip;
      JC_NO_R1END: take = stat.in2 || stat.r1_live;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      // dispatch: start setup, a finished arc answers with the empty result
      if (in_ch.operation == OP_START) begin
        pc_nxt = PC_ST0;
      end else if (stat.done) begin
        pc_nxt = PC_NUL;
      end else begin
        pc_nxt = PC_PX0;
      end
    end else if (busy_r && go) begin
      if (ctrl.item_end) begin
        busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = ctrl.target;
      end else begin
        pc_nxt = pc_r + PC_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_ST0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // datapath with the ellipse state and the pixel output register
  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .ld_cx     (in_ch.center_x),
    .ld_cy     (in_ch.center_y),
    .ld_rx     (in_ch.radius_x),
    .ld_ry     (in_ch.radius_y),
    .ctrl      (ctrl),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_px    (out_ch.pixel_x),
    .out_py    (out_ch.pixel_y),
    .out_pv    (out_ch.pixel_valid),
    .out_last  (out_ch.last_of_step),
    .out_fin   (out_ch.finished)
  );

  // step counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= PC_LAST))
    else $error("step counter beyond program end");

  // a step waiting on the output keeps its place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !go) |=> (busy_r && $stable(pc_r)))
    else $error("stalled step moved");

  // an accepted request starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> busy_r)
    else $error("accepted request not started");

  // the output register is only reloaded when it is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("pending pixel dropped");

endmodule

>>> rtl/mer_datapath.sv
// arithmetic datapath: ellipse state, shared multiply-accumulate and pixel output register
module mer_datapath #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [COORD_BITS-1:0]        ld_cx,
  input  logic [COORD_BITS-1:0]        ld_cy,
  input  logic [COORD_BITS-1:0]        ld_rx,
  input  logic [COORD_BITS-1:0]        ld_ry,
  input  mer_pkg::ctrl_t               ctrl,
  input  logic                         out_ready,
  output mer_pkg::stat_t               stat,
  output logic                         out_valid,
  output logic signed [COORD_BITS+1:0] out_px,
  output logic signed [COORD_BITS+1:0] out_py,
  output logic                         out_pv,
  output logic                         out_last,
  output logic                         out_fin
);
  import mer_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int XW  = C + 1;
  localparam int YW  = C + 2;
  localparam int PW  = C + 2;
  localparam int SQW = 2 * C;
  localparam int CH  = YW;
  localparam int TW  = 2 * CH;
  localparam int PRW = SQW + CH;

  logic [C-1:0]         cx_r, cx_nxt, cy_r, cy_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic [YW-1:0]        y_r, y_nxt;
  logic [DEC_BITS-1:0]  dec_r, dec_nxt, acc_r, acc_nxt;
  logic [STEP_BITS-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQW-1:0]       rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic [PRW-1:0]       prod_r, prod_nxt;
  logic [TW-1:0]        t_r, t_nxt;
  logic                 in2_r, in2_nxt, done_r, done_nxt, skip_r, skip_nxt;

  logic                 ov_r, ov_nxt;
  logic [PW-1:0]        px_r, px_nxt, py_r, py_nxt;
  logic                 pv_r, pv_nxt, last_r, last_nxt, fin_r, fin_nxt;

  logic [SQW-1:0]       mul_a;
  logic [CH-1:0]        mul_b;
  logic [YW:0]          ym1, ym1_neg;
  logic [YW-1:0]        ym1_abs;
  logic [PW-1:0]        xp, xn, yp, yn;
  logic                 out_free, dec_neg, dec_pos;
  logic [STEP_BITS-1:0] two_rx2, two_ry2;

  // |y-1|, its square equals the square of the signed value
  assign ym1     = {y_r[YW-1], y_r} - {{YW{1'b0}}, 1'b1};
  assign ym1_neg = ~ym1 + {{YW{1'b0}}, 1'b1};
  assign ym1_abs = ym1[YW] ? ym1_neg[YW-1:0] : ym1[YW-1:0];

  assign two_rx2 = STEP_BITS'({rx2_r, 1'b0});
  assign two_ry2 = STEP_BITS'({ry2_r, 1'b0});
  assign dec_neg = dec_r[DEC_BITS-1];
  assign dec_pos = !dec_r[DEC_BITS-1] && (|dec_r);

  assign xp = {2'b00, cx_r} + {1'b0, x_r};
  assign xn = {2'b00, cx_r} - {1'b0, x_r};
  assign yp = {2'b00, cy_r} + y_r;
  assign yn = {2'b00, cy_r} - y_r;

  assign out_free = !ov_r || out_ready;

  always_comb begin
    case (ctrl.ma)
      MA_RX:   mul_a = {{(SQW-C){1'b0}}, rx_r};
      MA_RY:   mul_a = {{(SQW-C){1'b0}}, ry_r};
      MA_RX2:  mul_a = rx2_r;
      MA_RY2:  mul_a = ry2_r;
      MA_X:    mul_a = {{(SQW-XW){1'b0}}, x_r};
      MA_YM1:  mul_a = {{(SQW-YW){1'b0}}, ym1_abs};
      default: mul_a = '0;
    endcase
    case (ctrl.mb)
      MB_RX:     mul_b = {{(CH-C){1'b0}}, rx_r};
      MB_RY:     mul_b = {{(CH-C){1'b0}}, ry_r};
      MB_X:      mul_b = {{(CH-XW){1'b0}}, x_r};
      MB_YM1:    mul_b = ym1_abs;
      MB_T_LO:   mul_b = t_r[CH-1:0];
      MB_T_HI:   mul_b = t_r[TW-1:CH];
      MB_RY2_LO: mul_b = ry2_r[CH-1:0];
      MB_RY2_HI: mul_b = {{(TW-SQW){1'b0}}, ry2_r[SQW-1:CH]};
      default:   mul_b = '0;
    endcase
  end

  assign prod_nxt = {{CH{1'b0}}, mul_a} * {{SQW{1'b0}}, mul_b};

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    dec_nxt  = dec_r;
    acc_nxt  = acc_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    rx2_nxt  = rx2_r;
    ry2_nxt  = ry2_r;
    t_nxt    = t_r;
    in2_nxt  = in2_r;
    done_nxt = done_r;
    skip_nxt = skip_r;

    if (load) begin
      cx_nxt   = ld_cx;
      cy_nxt   = ld_cy;
      rx_nxt   = ld_rx;
      ry_nxt   = ld_ry;
      x_nxt    = '0;
      y_nxt    = {2'b00, ld_ry};
      dx_nxt   = '0;
      in2_nxt  = 1'b0;
      done_nxt = 1'b0;
    end

    case (ctrl.top)
      T_PROD_X: t_nxt = TW'(prod_r) + TW'(x_r);
      T_PROD:   t_nxt = TW'(prod_r);
      default:  ;
    endcase

    case (ctrl.acc)
      AC_LOAD_Q: acc_nxt = DEC_BITS'(ry2_r[SQW-1:2]);
      AC_ADD:    acc_nxt = acc_r + DEC_BITS'(prod_r);
      AC_ADD_SH: acc_nxt = acc_r + DEC_BITS'({prod_r, {CH{1'b0}}});
      AC_SUB:    acc_nxt = acc_r - DEC_BITS'(prod_r);
      AC_SUB_SH: acc_nxt = acc_r - DEC_BITS'({prod_r, {CH{1'b0}}});
      default:   ;
    endcase

    case (ctrl.wr)
      WR_RX2: rx2_nxt = prod_r[SQW-1:0];
      WR_RY2: ry2_nxt = prod_r[SQW-1:0];
      WR_INIT: begin
        // product holds rx2 * ry here
        dec_nxt = DEC_BITS'(ry2_r) - DEC_BITS'(prod_r) + DEC_BITS'(rx2_r[SQW-1:2]);
        dy_nxt  = STEP_BITS'({prod_r, 1'b0});
      end
      WR_R2START: begin
        dec_nxt = acc_r;
        in2_nxt = 1'b1;
      end
      WR_ADV_R1: begin
        x_nxt    = x_r + {{(XW-1){1'b0}}, 1'b1};
        dx_nxt   = dx_r + two_ry2;
        skip_nxt = dec_neg;
        if (!dec_neg) begin
          y_nxt  = y_r - {{(YW-1){1'b0}}, 1'b1};
          dy_nxt = dy_r - two_rx2;
        end
      end
      WR_ADV_R2: begin
        y_nxt    = y_r - {{(YW-1){1'b0}}, 1'b1};
        dy_nxt   = dy_r - two_rx2;
        skip_nxt = dec_pos;
        if (!dec_pos) begin
          x_nxt  = x_r + {{(XW-1){1'b0}}, 1'b1};
          dx_nxt = dx_r + two_ry2;
        end
      end
      // slope terms enter the decision as unsigned words
      WR_DEC_ADD_DX:  dec_nxt = dec_r + DEC_BITS'(dx_r);
      WR_DEC_ADD_RY2: dec_nxt = dec_r + DEC_BITS'(ry2_r);
      WR_DEC_SUB_DY:  dec_nxt = dec_r - DEC_BITS'(dy_r);
      WR_DEC_ADD_RX2: dec_nxt = dec_r + DEC_BITS'(rx2_r);
      WR_CHK_DONE: begin
        if (in2_r && y_r[YW-1]) begin
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    ov_nxt   = ov_r && !out_ready;
    px_nxt   = px_r;
    py_nxt   = py_r;
    pv_nxt   = pv_r;
    last_nxt = last_r;
    fin_nxt  = fin_r;
    if ((ctrl.emit != EM_NONE) && out_free) begin
      ov_nxt   = 1'b1;
      pv_nxt   = 1'b1;
      last_nxt = 1'b0;
      fin_nxt  = 1'b0;
      case (ctrl.emit)
        EM_PIX0: begin
          px_nxt = xp; py_nxt = yp;
        end
        EM_PIX1: begin
          px_nxt = xn; py_nxt = yp;
        end
        EM_PIX2: begin
          px_nxt = xp; py_nxt = yn;
        end
        EM_PIX3: begin
          px_nxt = xn; py_nxt = yn; last_nxt = 1'b1;
        end
        default: begin
          px_nxt = '0; py_nxt = '0; pv_nxt = 1'b0; last_nxt = 1'b1; fin_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in2_r  <= 1'b0;
      done_r <= 1'b1;
      ov_r   <= 1'b0;
    end else begin
      in2_r  <= in2_nxt;
      done_r <= done_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    dec_r  <= dec_nxt;
    acc_r  <= acc_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    rx2_r  <= rx2_nxt;
    ry2_r  <= ry2_nxt;
    t_r    <= t_nxt;
    prod_r <= prod_nxt;
    skip_r <= skip_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    pv_r   <= pv_nxt;
    last_r <= last_nxt;
    fin_r  <= fin_nxt;
  end

  assign stat.in2      = in2_r;
  assign stat.done     = done_r;
  assign stat.skip     = skip_r;
  assign stat.r1_live  = $signed(dx_r) < $signed(dy_r);
  assign stat.out_free = out_free;

  assign out_valid = ov_r;
  assign out_px    = px_r;
  assign out_py    = py_r;
  assign out_pv    = pv_r;
  assign out_last  = last_r;
  assign out_fin   = fin_r;

endmodule
